[design/r2fft_pkg.sv]
package r2fft_pkg;

    localparam int MAX_POINTS_D   = 512;
    localparam int SAMPLE_BITS_D  = 16;
    localparam int TWIDDLE_BITS_D = 16;
    localparam int ACC_BITS       = 26;
    localparam int CFG_BITS       = 4;
    localparam int IDX_BITS       = 9;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_MUL,
        S_SUM,
        S_WR_A,
        S_WR_B,
        S_READ
    } t_state;

    typedef struct packed {
        logic ld_write;
        logic bf_addr_a;
        logic bf_addr_b;
        logic bf_mul;
        logic bf_sum;
        logic bf_wr_a;
        logic bf_wr_b;
        logic rd_addr;
        logic rd_out;
    } t_cmd;

    function automatic int clog2_floor(input int v);
        int r;
        r = 1;
        while (r < 12 && (2 << r) <= v) r++;
        return r;
    endfunction

    // Round to nearest, ties away from zero, saturate to tw_bits.
    function automatic int to_tw(input real v, input int tw_bits);
        real sc;
        int  q;
        int  hi;
        sc = v * (2.0 ** (tw_bits - 1));
        if (sc >= 0.0) q = int'($floor(sc + 0.5));
        else           q = -int'($floor(-sc + 0.5));
        hi = (1 << (tw_bits - 1)) - 1;
        if (q > hi) q = hi;
        if (q < -hi - 1) q = -hi - 1;
        return q;
    endfunction

endpackage

[design/r2fft_ctrl.sv]
module r2fft_ctrl #(
    parameter int LOG2_MAX = 9
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_operation,
    input  logic                     i_cfg_we,
    input  logic [r2fft_pkg::CFG_BITS-1:0] i_cfg_data,
    output logic                     o_busy,
    output r2fft_pkg::t_cmd          o_cmd,
    output logic [LOG2_MAX-1:0]      o_load_pos,
    output logic [LOG2_MAX-1:0]      o_addr_a,
    output logic [LOG2_MAX-1:0]      o_addr_b,
    output logic [LOG2_MAX-2:0]      o_tw_idx,
    output logic                     o_tw_zero,
    output logic [LOG2_MAX-1:0]      o_rd_idx,
    output logic                     o_rd_last,
    output logic                     o_not_ready
);
    localparam int CW = LOG2_MAX + 1;
    localparam int SW = $clog2(LOG2_MAX + 1);

    r2fft_pkg::t_state r_state, n_state;
    logic [SW-1:0]   r_size;
    logic [CW-1:0]   r_load_cnt;
    logic [LOG2_MAX-1:0] r_rd_ptr;
    logic            r_ready;
    logic [SW-1:0]   r_stage;
    logic [LOG2_MAX-1:0] r_bfly;
    logic            r_nr;

    logic [CW-1:0]   n_pts;
    logic [LOG2_MAX-1:0] mask;
    logic [LOG2_MAX-1:0] half, lowp, j;
    logic [LOG2_MAX-1:0] lc;
    logic [SW-1:0]   cfg_c;
    logic            last_bfly;
    logic            ld_restart;
    logic            frame_done;

    assign n_pts = CW'(1) << r_size;
    assign mask  = LOG2_MAX'(n_pts - CW'(1));
    assign half  = LOG2_MAX'(1) << r_stage;
    assign lowp  = r_bfly & (half - LOG2_MAX'(1));
    assign j     = ((r_bfly & ~(half - LOG2_MAX'(1))) << 1) | lowp;
    assign o_addr_a = j;
    assign o_addr_b = j | half;
    assign o_tw_idx = (LOG2_MAX-1)'(lowp << (SW'(LOG2_MAX - 1) - r_stage));
    assign o_tw_zero = (lowp == '0);
    assign last_bfly = (r_bfly == LOG2_MAX'((n_pts >> 1) - CW'(1)));
    assign ld_restart = r_ready || (r_load_cnt >= n_pts);
    assign frame_done = !ld_restart && (r_load_cnt + CW'(1) == n_pts);

    assign lc = r_load_cnt[LOG2_MAX-1:0];
    always_comb begin
        o_load_pos = '0;
        for (int i = 0; i < LOG2_MAX; i++)
            if (SW'(i) < r_size) o_load_pos[r_size - SW'(1) - SW'(i)] = lc[i];
    end

    assign o_rd_idx   = r_rd_ptr & mask;
    assign o_rd_last  = ((r_rd_ptr & mask) == mask);
    assign o_not_ready = r_nr;
    assign o_busy = (r_state != r2fft_pkg::S_IDLE);

    always_comb begin
        if (i_cfg_data == '0) cfg_c = SW'(1);
        else if ({1'b0, i_cfg_data} > 5'(LOG2_MAX)) cfg_c = SW'(LOG2_MAX);
        else cfg_c = SW'(i_cfg_data);
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            r2fft_pkg::S_IDLE: begin
                if (i_start && i_operation == r2fft_pkg::OP_LOAD) begin
                    o_cmd.ld_write = 1'b1;
                    if (frame_done) n_state = r2fft_pkg::S_RD_A;
                end else if (i_start) begin
                    o_cmd.rd_addr = 1'b1;
                    n_state = r2fft_pkg::S_READ;
                end
            end
            r2fft_pkg::S_RD_A: begin
                o_cmd.bf_addr_a = 1'b1;
                n_state = r2fft_pkg::S_RD_B;
            end
            r2fft_pkg::S_RD_B: begin
                o_cmd.bf_addr_b = 1'b1;
                n_state = r2fft_pkg::S_MUL;
            end
            r2fft_pkg::S_MUL: begin
                o_cmd.bf_mul = 1'b1;
                n_state = r2fft_pkg::S_SUM;
            end
            r2fft_pkg::S_SUM: begin
                o_cmd.bf_sum = 1'b1;
                n_state = r2fft_pkg::S_WR_A;
            end
            r2fft_pkg::S_WR_A: begin
                o_cmd.bf_wr_a = 1'b1;
                n_state = r2fft_pkg::S_WR_B;
            end
            r2fft_pkg::S_WR_B: begin
                o_cmd.bf_wr_b = 1'b1;
                if (last_bfly && r_stage == r_size - SW'(1)) n_state = r2fft_pkg::S_IDLE;
                else n_state = r2fft_pkg::S_RD_A;
            end
            r2fft_pkg::S_READ: begin
                o_cmd.rd_out = 1'b1;
                n_state = r2fft_pkg::S_IDLE;
            end
            default: n_state = r2fft_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= r2fft_pkg::S_IDLE;
            r_size <= SW'(LOG2_MAX < 9 ? LOG2_MAX : 9);
            r_load_cnt <= '0;
            r_rd_ptr <= '0;
            r_ready <= 1'b0;
            r_stage <= '0;
            r_bfly <= '0;
            r_nr <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_size <= cfg_c;
                r_load_cnt <= '0;
                r_rd_ptr <= '0;
                r_ready <= 1'b0;
            end else if (o_cmd.ld_write) begin
                r_ready <= 1'b0;
                r_rd_ptr <= '0;
                if (ld_restart) r_load_cnt <= CW'(1);
                else r_load_cnt <= r_load_cnt + CW'(1);
                if (frame_done) begin
                    r_stage <= '0;
                    r_bfly <= '0;
                end
            end else if (o_cmd.bf_wr_b) begin
                if (last_bfly) begin
                    r_bfly <= '0;
                    r_stage <= r_stage + SW'(1);
                    if (r_stage == r_size - SW'(1)) r_ready <= 1'b1;
                end else begin
                    r_bfly <= r_bfly + LOG2_MAX'(1);
                end
            end else if (o_cmd.rd_addr) begin
                r_nr <= !r_ready;
                if (r_ready) r_rd_ptr <= (r_rd_ptr + LOG2_MAX'(1)) & mask;
            end
        end
    end
endmodule

[design/r2fft_dp.sv]
module r2fft_dp #(
    parameter int LOG2_MAX     = 9,
    parameter int SAMPLE_BITS  = 16,
    parameter int TWIDDLE_BITS = 16
) (
    input  logic                          i_clk,
    input  r2fft_pkg::t_cmd               i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [LOG2_MAX-1:0]           i_load_pos,
    input  logic [LOG2_MAX-1:0]           i_addr_a,
    input  logic [LOG2_MAX-1:0]           i_addr_b,
    input  logic [LOG2_MAX-2:0]           i_tw_idx,
    input  logic                          i_tw_zero,
    input  logic [LOG2_MAX-1:0]           i_rd_idx,
    input  logic                          i_rd_last,
    input  logic                          i_not_ready,
    output logic                          o_bin_valid,
    output logic signed [r2fft_pkg::ACC_BITS-1:0] o_bin_real,
    output logic signed [r2fft_pkg::ACC_BITS-1:0] o_bin_imag,
    output logic [r2fft_pkg::IDX_BITS-1:0] o_bin_index,
    output logic                          o_last_bin,
    output logic                          o_status
);
    localparam int AB = r2fft_pkg::ACC_BITS;
    localparam int TB = TWIDDLE_BITS;
    localparam int DEPTH = 1 << LOG2_MAX;
    localparam int PB = AB + TB + 1;
    localparam logic signed [AB+1:0] HI = (AB+2)'((1 << (AB - 1)) - 1);
    localparam logic signed [AB+1:0] LO = -(AB+2)'(1 << (AB - 1));

    logic [2*AB-1:0] mem [DEPTH];
    logic [2*AB-1:0] r_q;
    logic [LOG2_MAX-1:0] mem_addr;
    logic            mem_we;
    logic [2*AB-1:0] mem_wd;

    logic signed [TB-1:0] rom_c [DEPTH/2];
    logic signed [TB-1:0] rom_s [DEPTH/2];

    logic signed [TB-1:0] r_c, r_s;
    logic signed [AB-1:0] r_ar, r_ai, r_xr, r_xi;
    logic signed [PB-1:0] r_p0, r_p1, r_p2, r_p3;
    logic r_zero;
    logic signed [AB-1:0] r_sr, r_si, r_dr, r_di;
    logic [r2fft_pkg::IDX_BITS-1:0] r_idx;
    logic r_last;

    function automatic logic signed [AB-1:0] sat(input logic signed [AB+1:0] v);
        if (v > HI) return HI[AB-1:0];
        if (v < LO) return LO[AB-1:0];
        return v[AB-1:0];
    endfunction

    for (genvar g = 0; g < DEPTH / 2; g++) begin : g_tw
        localparam real ANG = 2.0 * 3.14159265358979323846 * g / DEPTH;
        localparam logic signed [TB-1:0] TW_C = TB'(r2fft_pkg::to_tw($cos(ANG), TB));
        localparam logic signed [TB-1:0] TW_S = TB'(r2fft_pkg::to_tw($sin(ANG), TB));
        assign rom_c[g] = TW_C;
        assign rom_s[g] = TW_S;
    end

    logic signed [PB:0] tr_full, ti_full;
    logic signed [AB+1:0] tr, ti;
    logic signed [PB:0] rnd;
    assign rnd = (PB+1)'(1) << (TB - 2);
    assign tr_full = (PB+1)'(r_p0) + (PB+1)'(r_p1) + rnd;
    assign ti_full = (PB+1)'(r_p2) - (PB+1)'(r_p3) + rnd;
    assign tr = r_zero ? (AB+2)'(r_xr) : (AB+2)'(tr_full >>> (TB - 1));
    assign ti = r_zero ? (AB+2)'(r_xi) : (AB+2)'(ti_full >>> (TB - 1));

    always_comb begin
        mem_we = 1'b0;
        mem_addr = i_addr_a;
        mem_wd = {r_sr, r_si};
        if (i_cmd.ld_write) begin
            mem_we = 1'b1;
            mem_addr = i_load_pos;
            mem_wd = {(AB)'(i_sample), {AB{1'b0}}};
        end else if (i_cmd.bf_addr_b || i_cmd.bf_wr_b) begin
            mem_addr = i_addr_b;
            if (i_cmd.bf_wr_b) begin
                mem_we = 1'b1;
                mem_wd = {r_dr, r_di};
            end
        end else if (i_cmd.bf_wr_a) begin
            mem_we = 1'b1;
        end else if (i_cmd.rd_addr) begin
            mem_addr = i_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wd;
        r_q <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bf_addr_a) begin
            r_c <= rom_c[i_tw_idx];
            r_s <= rom_s[i_tw_idx];
            r_zero <= i_tw_zero;
        end
        if (i_cmd.bf_addr_b) begin
            r_ar <= r_q[2*AB-1:AB];
            r_ai <= r_q[AB-1:0];
        end
        if (i_cmd.bf_mul) begin
            r_xr <= r_q[2*AB-1:AB];
            r_xi <= r_q[AB-1:0];
            r_p0 <= PB'($signed(r_q[2*AB-1:AB]) * r_c);
            r_p1 <= PB'($signed(r_q[AB-1:0]) * r_s);
            r_p2 <= PB'($signed(r_q[AB-1:0]) * r_c);
            r_p3 <= PB'($signed(r_q[2*AB-1:AB]) * r_s);
        end
        if (i_cmd.bf_sum) begin
            r_sr <= sat((AB+2)'(r_ar) + tr);
            r_si <= sat((AB+2)'(r_ai) + ti);
            r_dr <= sat((AB+2)'(r_ar) - tr);
            r_di <= sat((AB+2)'(r_ai) - ti);
        end
        if (i_cmd.rd_addr) begin
            r_idx <= r2fft_pkg::IDX_BITS'(i_rd_idx);
            r_last <= i_rd_last;
        end
    end

    assign o_bin_valid = i_cmd.rd_out;
    assign o_status    = i_not_ready;
    assign o_bin_real  = i_not_ready ? '0 : r_q[2*AB-1:AB];
    assign o_bin_imag  = i_not_ready ? '0 : r_q[AB-1:0];
    assign o_bin_index = i_not_ready ? '0 : r_idx;
    assign o_last_bin  = i_not_ready ? 1'b0 : r_last;
endmodule

[design/radix2_dit_fft_unit.sv]
// Radix-2 decimation-in-time FFT of a real frame, in place in one working memory.
// Command channel: start with i_operation / i_sample is taken when busy is low.
//   Load (operation 0) writes a sample to its bit-reversed slot;
//   loads can be taken every cycle.
//   The load that completes 2^size_log2 samples starts the transform: one shared
//   butterfly unit; each butterfly runs two memory reads, multiply, add and
//   two writes; (N/2)*log2(N) butterflies; busy stays high throughout.
//   Read (operation 1) returns one bin in the next cycle on the o_bin_* ports,
//   marked by o_bin_valid for one cycle; busy is high for that one cycle,
//   so no new read is taken while its bin is being returned.
//   A read with no finished frame returns status 1 and zero fields.
// Config: i_cfg_we / i_cfg_data write size_log2 (clamped), abandoning any frame.
// Reset: size_log2 = 9, no frame loaded; memory contents are not cleared.
// Results cannot be held off by the receiver.
module radix2_dit_fft_unit #(
    parameter int MAX_POINTS   = r2fft_pkg::MAX_POINTS_D,
    parameter int SAMPLE_BITS  = r2fft_pkg::SAMPLE_BITS_D,
    parameter int TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS_D
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_operation,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                    i_cfg_we,
    input  logic [r2fft_pkg::CFG_BITS-1:0] i_cfg_data,
    output logic                    o_bin_valid,
    output logic signed [r2fft_pkg::ACC_BITS-1:0] o_bin_real,
    output logic signed [r2fft_pkg::ACC_BITS-1:0] o_bin_imag,
    output logic [r2fft_pkg::IDX_BITS-1:0] o_bin_index,
    output logic                    o_last_bin,
    output logic                    o_status
);
    localparam int LOG2_MAX = r2fft_pkg::clog2_floor(MAX_POINTS);

    r2fft_pkg::t_cmd cmd;
    logic [LOG2_MAX-1:0] load_pos, addr_a, addr_b, rd_idx;
    logic [LOG2_MAX-2:0] tw_idx;
    logic tw_zero, rd_last, not_ready;

    r2fft_ctrl #(.LOG2_MAX(LOG2_MAX)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_operation(i_operation),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data), .o_busy(busy), .o_cmd(cmd),
        .o_load_pos(load_pos), .o_addr_a(addr_a), .o_addr_b(addr_b),
        .o_tw_idx(tw_idx), .o_tw_zero(tw_zero), .o_rd_idx(rd_idx),
        .o_rd_last(rd_last), .o_not_ready(not_ready)
    );

    r2fft_dp #(
        .LOG2_MAX(LOG2_MAX), .SAMPLE_BITS(SAMPLE_BITS), .TWIDDLE_BITS(TWIDDLE_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_sample(i_sample),
        .i_load_pos(load_pos), .i_addr_a(addr_a), .i_addr_b(addr_b),
        .i_tw_idx(tw_idx), .i_tw_zero(tw_zero), .i_rd_idx(rd_idx),
        .i_rd_last(rd_last), .i_not_ready(not_ready), .o_bin_valid(o_bin_valid),
        .o_bin_real(o_bin_real), .o_bin_imag(o_bin_imag), .o_bin_index(o_bin_index),
        .o_last_bin(o_last_bin), .o_status(o_status)
    );
endmodule

[bench/radix2_dit_fft_unit_test.sv]
module radix2_dit_fft_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS     = r2fft_pkg::MAX_POINTS_D;
    localparam int LOG2_MAX = 9;
    localparam int TWB      = r2fft_pkg::TWIDDLE_BITS_D;
    localparam int AB       = r2fft_pkg::ACC_BITS;
    localparam int SB       = r2fft_pkg::SAMPLE_BITS_D;
    localparam int IB       = r2fft_pkg::IDX_BITS;
    localparam int CB       = r2fft_pkg::CFG_BITS;
    localparam longint ACC_HI = (longint'(1) <<< (AB - 1)) - 1;
    localparam longint ACC_LO = -(longint'(1) <<< (AB - 1));
    localparam int CYCLE_LIMIT = 3000000;
    localparam int ITEMS = 1700;

    typedef struct {
        logic                 op;
        logic signed [SB-1:0] smp;
    } t_cmd_item;

    typedef struct {
        logic signed [AB-1:0] re;
        logic signed [AB-1:0] im;
        logic [IB-1:0]        idx;
        logic                 last;
        logic                 stat;
    } t_bin;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_operation;
    logic signed [SB-1:0] i_sample;
    logic                 i_cfg_we;
    logic [CB-1:0]        i_cfg_data;
    logic                 o_bin_valid;
    logic signed [AB-1:0] o_bin_real;
    logic signed [AB-1:0] o_bin_imag;
    logic [IB-1:0]        o_bin_index;
    logic                 o_last_bin;
    logic                 o_status;

    radix2_dit_fft_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_sample(i_sample),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_bin_valid(o_bin_valid), .o_bin_real(o_bin_real), .o_bin_imag(o_bin_imag),
        .o_bin_index(o_bin_index), .o_last_bin(o_last_bin), .o_status(o_status)
    );

    t_cmd_item feed[$];
    t_bin      bins_due[$];
    int        idle_pct;
    int        errors;
    int        cycles;
    int        n_items;

    // FFT model state
    longint    fft_re[NPTS];
    longint    fft_im[NPTS];
    longint    cos_rom[NPTS/2];
    longint    sin_rom[NPTS/2];
    int        pts_log2;
    int        loaded;
    int        rd_ptr;
    bit        ready;

    always #10 i_clk = ~i_clk;

    function automatic longint quant_tw(real v);
        real    sc;
        longint q;
        sc = v * (2.0 ** (TWB - 1));
        if (sc >= 0.0) q = longint'($floor(sc + 0.5));
        else q = -longint'($floor(-sc + 0.5));
        if (q > (1 <<< (TWB - 1)) - 1) q = (1 <<< (TWB - 1)) - 1;
        if (q < -(1 <<< (TWB - 1))) q = -(1 <<< (TWB - 1));
        return q;
    endfunction

    function automatic longint clip_acc(longint v);
        return v > ACC_HI ? ACC_HI : (v < ACC_LO ? ACC_LO : v);
    endfunction

    function automatic int bitrev(int v, int bits);
        int r;
        r = 0;
        for (int i = 0; i < bits; i++) r |= ((v >> i) & 1) << (bits - 1 - i);
        return r;
    endfunction

    function automatic void transform();
        int     n;
        int     half;
        int     stride;
        int     j;
        int     h;
        int     m;
        longint tr;
        longint ti;
        longint ar;
        longint ai;
        n = 1 << pts_log2;
        for (int len = 2; len <= n; len <<= 1) begin
            half = len >> 1;
            stride = NPTS / len;
            for (int b = 0; b < n; b += len) begin
                for (int p = 0; p < half; p++) begin
                    j = b + p;
                    h = j + half;
                    m = p * stride;
                    ar = fft_re[j];
                    ai = fft_im[j];
                    tr = fft_re[h];
                    ti = fft_im[h];
                    if (m != 0) begin
                        tr = (fft_re[h] * cos_rom[m] + fft_im[h] * sin_rom[m]
                              + (1 <<< (TWB - 2))) >>> (TWB - 1);
                        ti = (fft_im[h] * cos_rom[m] - fft_re[h] * sin_rom[m]
                              + (1 <<< (TWB - 2))) >>> (TWB - 1);
                    end
                    fft_re[j] = clip_acc(ar + tr);
                    fft_im[j] = clip_acc(ai + ti);
                    fft_re[h] = clip_acc(ar - tr);
                    fft_im[h] = clip_acc(ai - ti);
                end
            end
        end
    endfunction

    function automatic void set_size(int v);
        pts_log2 = v < 1 ? 1 : (v > LOG2_MAX ? LOG2_MAX : v);
        loaded = 0;
        rd_ptr = 0;
        ready = 0;
    endfunction

    function automatic void predict(logic op, logic signed [SB-1:0] smp);
        int   n;
        int   k;
        t_bin b;
        n = 1 << pts_log2;
        if (op == r2fft_pkg::OP_LOAD) begin
            if (ready || loaded >= n) begin
                ready = 0;
                loaded = 0;
                rd_ptr = 0;
            end
            k = bitrev(loaded, pts_log2);
            fft_re[k] = smp;
            fft_im[k] = 0;
            loaded++;
            if (loaded == n) begin
                transform();
                ready = 1;
                rd_ptr = 0;
            end
        end else begin
            b = '{re: '0, im: '0, idx: '0, last: 1'b0, stat: 1'b1};
            if (ready) begin
                k = rd_ptr & (n - 1);
                b.re = fft_re[k][AB-1:0];
                b.im = fft_im[k][AB-1:0];
                b.idx = k[IB-1:0];
                b.last = (k == n - 1);
                b.stat = 1'b0;
                rd_ptr = (k + 1) & (n - 1);
            end
            bins_due.push_back(b);
        end
    endfunction

    // driver
    t_cmd_item nxt;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) predict(i_operation, i_sample);
            if (!start || !busy) begin
                if (feed.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    nxt = feed.pop_front();
                    start <= 1'b1;
                    i_operation <= nxt.op;
                    i_sample <= nxt.smp;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    t_bin want;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("radix2_dit_fft_unit_test: errors");
            $finish;
        end
        if (i_rst_n && o_bin_valid) begin
            if (bins_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected bin idx=%0d", o_bin_index);
            end else begin
                want = bins_due.pop_front();
                if (o_bin_real !== want.re || o_bin_imag !== want.im
                    || o_bin_index !== want.idx || o_last_bin !== want.last
                    || o_status !== want.stat) begin
                    errors++;
                    if (errors <= 10)
                        $display("bin mismatch exp re=%0d im=%0d idx=%0d last=%0b st=%0b %s",
                                 want.re, want.im, want.idx, want.last, want.stat,
                                 $sformatf("got re=%0d im=%0d idx=%0d last=%0b st=%0b",
                                 o_bin_real, o_bin_imag, o_bin_index, o_last_bin,
                                 o_status));
                end
            end
        end
    end

    function automatic logic signed [SB-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '0;
            default: return SB'($urandom);
        endcase
    endfunction

    task automatic push(logic op, logic signed [SB-1:0] smp);
        feed.push_back('{op: op, smp: smp});
        n_items++;
    endtask

    task automatic settle();
        while (feed.size() > 0 || start || bins_due.size() > 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_size(int v);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v[CB-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        set_size(v);
        @(posedge i_clk);
    endtask

    task automatic frame(int n, int reads);
        for (int i = 0; i < n; i++) push(r2fft_pkg::OP_LOAD, pick_sample());
        for (int i = 0; i < reads; i++) push(r2fft_pkg::OP_READ, pick_sample());
    endtask

    int sz;
    int n;
    int nf;
    int phase;
    initial begin
        i_clk = 0;
        i_rst_n = 0;
        start = 0;
        i_operation = 0;
        i_sample = 0;
        i_cfg_we = 0;
        i_cfg_data = 0;
        errors = 0;
        cycles = 0;
        n_items = 0;
        idle_pct = 0;
        for (int m = 0; m < NPTS / 2; m++) begin
            cos_rom[m] = quant_tw($cos(2.0 * 3.14159265358979323846 * m / NPTS));
            sin_rom[m] = quant_tw($sin(2.0 * 3.14159265358979323846 * m / NPTS));
        end
        set_size(9);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        push(r2fft_pkg::OP_READ, 0);
        write_size(0);
        push(r2fft_pkg::OP_LOAD, 16'sh7fff);
        push(r2fft_pkg::OP_READ, 0);
        push(r2fft_pkg::OP_LOAD, 16'sh8000);
        repeat (3) push(r2fft_pkg::OP_READ, 0);
        write_size(2);
        push(r2fft_pkg::OP_LOAD, 16'sh7fff);
        push(r2fft_pkg::OP_LOAD, 16'sh8000);
        push(r2fft_pkg::OP_LOAD, 16'sh7fff);
        push(r2fft_pkg::OP_LOAD, 16'sh8000);
        repeat (5) push(r2fft_pkg::OP_READ, 0);
        push(r2fft_pkg::OP_LOAD, 16'sh0001);
        push(r2fft_pkg::OP_READ, 0);
        write_size(15);
        for (int i = 0; i < 512; i++) push(r2fft_pkg::OP_LOAD, 16'sh7fff);
        repeat (3) push(r2fft_pkg::OP_READ, 0);
        settle();
        write_size(3);

        phase = 0;
        while (n_items < ITEMS) begin
            idle_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 69 : 16);
            sz = $urandom_range(1, 6);
            if ($urandom_range(9) == 0 && n_items < ITEMS - 600) sz = $urandom_range(0, 15);
            write_size(sz);
            n = 1 << (sz < 1 ? 1 : (sz > LOG2_MAX ? LOG2_MAX : sz));
            nf = n > 64 ? 1 : 6;
            for (int f = 0; f < nf && n_items < ITEMS; f++) begin
                case ($urandom_range(9))
                    0: frame($urandom_range(0, n - 1), $urandom_range(0, 3));
                    1: push(1'($urandom_range(1)), pick_sample());
                    default: frame(n, n > 64 ? $urandom_range(0, 8)
                                             : $urandom_range(0, n + 2));
                endcase
            end
            phase++;
        end
        settle();
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("radix2_dit_fft_unit_test: clean");
        else $display("radix2_dit_fft_unit_test: errors");
        $finish;
    end

endmodule
